/* sv/lgs_pkg.sv */
`default_nettype none

package lgs_pkg;

  // Grid geometry
  localparam int MAX_COLS   = 32;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int MAX_ROWS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);

  // Configuration register widths and reset values
  localparam int CFG_COLS_W = 6;
  localparam int CFG_ROWS_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_COLS_W-1:0] GRID_COLS_RST = CFG_COLS_W'(30);
  localparam logic [CFG_ROWS_W-1:0] GRID_ROWS_RST = CFG_ROWS_W'(30);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Vertical triple of one column: [2] row above, [1] middle row, [0] row below
  typedef logic [2:0] col_triple_t;

  // One work item sitting in the compute stage
  typedef struct packed {
    logic [COL_W-1:0] col;       // column of the incoming cell
    logic [ROW_W-1:0] orow;      // row index of the cells it emits
    logic             alive_in;  // incoming cell value (zero for flush items)
    logic             end_row;   // last column of a row
    logic             up_ok;     // row above the emitted row exists
    logic             mid_ok;    // emitted row exists in the line memory
    logic             emit;      // item produces results at all
    logic             tag_last;  // mark the final result with tlast
    logic             eog;       // final result ends the generation
  } work_t;

  // One result transaction
  typedef struct packed {
    logic             eog;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             alive;
  } res_t;

  // B3/S23 rule on a 3x3 neighborhood given as left, center and right columns
  function automatic logic life_next(input col_triple_t l, input col_triple_t c,
                                     input col_triple_t r);
    logic [3:0] n;
    n = 4'(c[2]) + 4'(c[0]);
    for (int i = 0; i < 3; i++) begin
      n = n + 4'(l[i]) + 4'(r[i]);
    end
    return (n == 4'd3) || ((n == 4'd2) && c[1]);
  endfunction

endpackage

`default_nettype wire

/* sv/life_generation_stencil.sv */
// Channel | Dir | Handshake         | Payload
// --------+-----+-------------------+---------------------------------------------------------
// in      | in  | in_tvalid/tready  | tdata[0] cell_alive
// out     | out | out_tvalid/tready | tdata[0] alive, [10:1] row, [15:11] col; tlast; tuser eog
// cfg     | in  | cfg_we            | cfg_index 0 grid_cols, 1 grid_rows; cfg_wdata value
//
// One cell is accepted per cycle while the compute stage is free and no flush runs; a row-end
// cell with two results (from row 1 on, grid wider than one column) holds the input until its
// second result is pushed. The frame-final cell starts a flush of one item per effective
// column that re-reads the last row from the line memory; the input is held meanwhile.
// A taken cell waits in the compute stage register until its first result fits the output
// buffer. Reset is synchronous and clears control state only; unwritten rows are masked.
// Two output entries hold results while out_tready is low; with both full the input stalls.
`default_nettype none

module life_generation_stencil (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // cfg_wdata: grid_cols [5:0] or grid_rows [10:0]
  input  wire                                  cfg_we,
  input  wire  [lgs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lgs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [lgs_pkg::IN_DATA_W-1:0]        in_tdata,   // [0] cell_alive
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [lgs_pkg::OUT_DATA_W-1:0]       out_tdata,  // [0] next_alive, [10:1] out_row,
                                                           // [15:11] out_col
  output logic                                 out_tlast,  // last_of_run
  output logic                                 out_tuser   // end_of_generation
);
  import lgs_pkg::*;

  // Configuration and effective geometry
  logic [CFG_COLS_W-1:0] grid_cols_r;
  logic [CFG_ROWS_W-1:0] grid_rows_r;
  logic [CFG_COLS_W-1:0] cols_eff;
  logic [CFG_ROWS_W-1:0] rows_eff;
  logic [CFG_COLS_W-1:0] cols_eff_m1;
  logic [CFG_ROWS_W-1:0] rows_eff_m1;
  logic [COL_W-1:0]      cols_m1;
  logic [ROW_W-1:0]      rows_m1;

  // Raster counters and flush sequencer
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic             fl_active_r;
  logic [COL_W-1:0] fl_col_r;
  logic [ROW_W-1:0] fl_row_r;

  // Line memory: per column {row r-2, row r-1} relative to the incoming row
  logic [1:0]       line_mem [MAX_COLS];
  logic [1:0]       rd_data_r;
  logic             fwd_hit_r;
  logic [1:0]       fwd_data_r;
  logic [COL_W-1:0] rd_addr;
  logic [1:0]       wr_data;

  // Compute stage
  logic        s1_valid_r;
  work_t       s1_r;
  work_t       s1_nxt;
  logic        second_r;
  col_triple_t win1_r;
  col_triple_t win2_r;
  col_triple_t t_cur;
  logic [1:0]  rd_col;
  logic        has_a;
  logic        has_b;
  logic        sel_b;
  logic        is_last;
  logic        push;
  logic        retire;
  logic        s1_free;
  logic        in_acc;
  logic        inj;
  logic        take;
  logic        end_row_in;
  logic        end_frame_in;
  logic        fl_end;
  res_t        res;
  col_triple_t a_left;
  col_triple_t b_left;

  // Output buffer
  logic out_valid_r;
  res_t out_data_r;
  logic skid_valid_r;
  res_t skid_data_r;
  logic can_push;
  logic pop;

  // Clamp the configured sizes to the supported range
  always_comb begin
    if (grid_cols_r == '0) begin
      cols_eff = CFG_COLS_W'(1);
    end else if (grid_cols_r > CFG_COLS_W'(MAX_COLS)) begin
      cols_eff = CFG_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_r;
    end
    if (grid_rows_r == '0) begin
      rows_eff = CFG_ROWS_W'(1);
    end else if (grid_rows_r > CFG_ROWS_W'(MAX_ROWS)) begin
      rows_eff = CFG_ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
    cols_eff_m1 = cols_eff - CFG_COLS_W'(1);
    rows_eff_m1 = rows_eff - CFG_ROWS_W'(1);
    cols_m1     = cols_eff_m1[COL_W-1:0];
    rows_m1     = rows_eff_m1[ROW_W-1:0];
  end

  // Pick the source of the next work item: input cell or flush column
  always_comb begin
    can_push     = !skid_valid_r;
    pop          = out_valid_r && out_tready;
    s1_free      = !s1_valid_r || retire;
    in_tready    = !fl_active_r && s1_free;
    in_acc       = in_tvalid && in_tready;
    inj          = fl_active_r && s1_free;
    take         = in_acc || inj;
    end_row_in   = (col_cnt_r == cols_m1);
    end_frame_in = end_row_in && (row_cnt_r == rows_m1);
    fl_end       = (fl_col_r == cols_m1);
    rd_addr      = fl_active_r ? fl_col_r : col_cnt_r;

    if (fl_active_r) begin
      s1_nxt.col      = fl_col_r;
      s1_nxt.orow     = fl_row_r;
      s1_nxt.alive_in = 1'b0;
      s1_nxt.end_row  = fl_end;
      s1_nxt.up_ok    = (fl_row_r != '0);
      s1_nxt.mid_ok   = 1'b1;
      s1_nxt.emit     = 1'b1;
      s1_nxt.tag_last = fl_end;
      s1_nxt.eog      = fl_end;
    end else begin
      s1_nxt.col      = col_cnt_r;
      s1_nxt.orow     = row_cnt_r - ROW_W'(1);
      s1_nxt.alive_in = in_tdata[0];
      s1_nxt.end_row  = end_row_in;
      s1_nxt.up_ok    = (row_cnt_r > ROW_W'(1));
      s1_nxt.mid_ok   = (row_cnt_r != '0);
      s1_nxt.emit     = (row_cnt_r != '0);
      s1_nxt.tag_last = !end_frame_in;
      s1_nxt.eog      = 1'b0;
    end
  end

  // Form the current column and the result it releases
  always_comb begin
    rd_col  = fwd_hit_r ? fwd_data_r : rd_data_r;
    t_cur   = {rd_col[1] & s1_r.up_ok, rd_col[0] & s1_r.mid_ok, s1_r.alive_in};
    wr_data = {rd_col[0], s1_r.alive_in};
    has_a   = s1_r.emit && (s1_r.col != '0);
    has_b   = s1_r.emit && s1_r.end_row;
    sel_b   = !has_a || second_r;
    is_last = !(has_a && has_b && !second_r);
    a_left  = (s1_r.col > COL_W'(1)) ? win2_r : '0;
    b_left  = (s1_r.col != '0) ? win1_r : '0;

    res.row   = s1_r.orow;
    res.last  = s1_r.tag_last && is_last;
    res.eog   = s1_r.eog && is_last;
    if (sel_b) begin
      res.col   = s1_r.col;
      res.alive = life_next(b_left, t_cur, '0);
    end else begin
      res.col   = s1_r.col - COL_W'(1);
      res.alive = life_next(a_left, win1_r, t_cur);
    end

    push   = s1_valid_r && (has_a || has_b) && can_push;
    retire = s1_valid_r && (!(has_a || has_b) || (can_push && is_last));
  end

  // Line memory: write back at retire, read for the item being taken
  always_ff @(posedge clk) begin
    if (retire) begin
      line_mem[s1_r.col] <= wr_data;
    end
    if (take) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  // Forward a write that lands on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (take) begin
      fwd_hit_r <= retire && (s1_r.col == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fwd_data_r <= wr_data;
    end
  end

  // Configuration, raster counters and flush sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_COLS_RST;
      grid_rows_r <= GRID_ROWS_RST;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      fl_active_r <= 1'b0;
      fl_col_r    <= '0;
      fl_row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_COLS: begin
          grid_cols_r <= cfg_wdata[CFG_COLS_W-1:0];
        end
        REG_GRID_ROWS: begin
          grid_rows_r <= cfg_wdata[CFG_ROWS_W-1:0];
        end
        default: begin
        end
      endcase
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      fl_active_r <= 1'b0;
      fl_col_r    <= '0;
    end else if (inj) begin
      fl_col_r <= fl_col_r + COL_W'(1);
      if (fl_end) begin
        fl_active_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (end_frame_in) begin
        col_cnt_r   <= '0;
        row_cnt_r   <= '0;
        fl_active_r <= 1'b1;
        fl_col_r    <= '0;
        fl_row_r    <= row_cnt_r;
      end else if (end_row_in) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + COL_W'(1);
      end
    end
  end

  // Compute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      second_r   <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
      if (retire) begin
        second_r <= 1'b0;
      end else if (push) begin
        second_r <= 1'b1;
      end
    end
  end

  // Compute stage payload and column window
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
    if (retire) begin
      win1_r <= t_cur;
      win2_r <= win1_r;
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.col, out_data_r.row, out_data_r.alive};
  assign out_tlast  = out_data_r.last;
  assign out_tuser  = out_data_r.eog;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a valid output register");

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    fl_active_r |-> !in_tready)
    else $error("input ready during last-row flush");

  a_eog_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.eog) |-> (res.last && !fl_active_r))
    else $error("end of generation without tlast or with flush pending");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into a full output buffer");

  a_second_follows_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !retire) |=> (second_r && s1_valid_r))
    else $error("second result of a row end lost");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lgs_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 200;
  localparam int TALL_CELLS   = 24;

  // One next-generation cell as it leaves the block
  typedef struct packed {
    logic             alive;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             eog;
  } cell_result_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_CELL, STEP_CELL_TYPED} plan_kind_t;

  typedef struct packed {
    plan_kind_t                 kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic                       alive_in;
    cell_result_t               want;
  } plan_step_t;

  localparam cell_result_t NO_RESULT = '0;
  // A 1x1 grid: the only cell has no neighbors and is always dead next
  localparam cell_result_t LONE_DIES = '{1'b0, 10'd0, 5'd0, 1'b1, 1'b1};

  localparam plan_step_t PLAN [28] = '{
    // single cell grid, both sizes written as zero
    '{STEP_CFG,        REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CFG,        REG_GRID_ROWS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL_TYPED, REG_GRID_COLS, 11'd0,    1'b1, LONE_DIES},
    '{STEP_CELL_TYPED, REG_GRID_COLS, 11'd0,    1'b0, LONE_DIES},
    // one column of three live cells: only the middle one survives
    '{STEP_CFG,        REG_GRID_COLS, 11'd1,    1'b0, NO_RESULT},
    '{STEP_CFG,        REG_GRID_ROWS, 11'd3,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    // 3x3 blinker: horizontal bar turns vertical, births at top and bottom
    '{STEP_CFG,        REG_GRID_COLS, 11'd3,    1'b0, NO_RESULT},
    '{STEP_CFG,        REG_GRID_ROWS, 11'd3,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b0, NO_RESULT},
    // 2x2 block, upper write bits set, frame restarted after one cell
    '{STEP_CFG,        REG_GRID_COLS, 11'h7C2,  1'b0, NO_RESULT},
    '{STEP_CFG,        REG_GRID_ROWS, 11'd2,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CFG,        REG_GRID_ROWS, 11'd2,    1'b0, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT},
    '{STEP_CELL,       REG_GRID_COLS, 11'd0,    1'b1, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // Predictor state: registers, row lines and raster position
  logic [CFG_COLS_W-1:0] grid_cols_q = GRID_COLS_RST;
  logic [CFG_ROWS_W-1:0] grid_rows_q = GRID_ROWS_RST;
  logic [MAX_COLS-1:0]   line_up = '0;
  logic [MAX_COLS-1:0]   line_mid = '0;
  logic [MAX_COLS-1:0]   line_cur = '0;
  int                    at_row = 0;
  int                    at_col = 0;

  cell_result_t next_gen_q[$];
  cell_result_t seen;
  cell_result_t owed;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           random_cells = 0;
  bit           hold_req = 1'b0;

  life_generation_stencil dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int live_cols();
    int c;
    c = int'(grid_cols_q);
    if (c == 0) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int live_rows();
    int r;
    r = int'(grid_rows_q);
    if (r == 0) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  // Cells off the grid read as dead
  function automatic int line_bit(input logic [MAX_COLS-1:0] line, input int col,
                                  input int cols);
    if (col < 0 || col >= cols) return 0;
    return int'(line[col]);
  endfunction

  // B3/S23 on the column col of mid, with up and down as its vertical neighbors
  function automatic logic rule_b3s23(input logic [MAX_COLS-1:0] up,
                                      input logic [MAX_COLS-1:0] mid,
                                      input logic [MAX_COLS-1:0] down,
                                      input int col, input int cols);
    int n;
    n = 0;
    for (int d = -1; d <= 1; d++) begin
      n += line_bit(up, col + d, cols) + line_bit(down, col + d, cols);
      if (d != 0) n += line_bit(mid, col + d, cols);
    end
    return (n == 3) || (n == 2 && line_bit(mid, col, cols) == 1);
  endfunction

  function automatic void wipe_lines();
    line_up  = '0;
    line_mid = '0;
    line_cur = '0;
    at_row   = 0;
    at_col   = 0;
  endfunction

  // Advance the predictor by one cell and queue the cells it releases
  task automatic evolve_cell(input logic alive, input bit record);
    cell_result_t batch [MAX_COLS + 2];
    int           cols;
    int           rows;
    int           c;
    int           r;
    int           n;
    bit           end_row;
    bit           end_frame;
    cols = live_cols();
    rows = live_rows();
    c = (at_col >= cols) ? cols - 1 : at_col;
    r = (at_row >= rows) ? rows - 1 : at_row;
    if (alive) line_cur[c] = 1'b1;
    end_row   = (c == cols - 1);
    end_frame = end_row && (r == rows - 1);
    n = 0;
    if (r >= 1) begin
      if (c >= 1) begin
        batch[n] = '{rule_b3s23(line_up, line_mid, line_cur, c - 1, cols),
                     ROW_W'(r - 1), COL_W'(c - 1), 1'b0, 1'b0};
        n++;
      end
      if (end_row) begin
        batch[n] = '{rule_b3s23(line_up, line_mid, line_cur, c, cols),
                     ROW_W'(r - 1), COL_W'(c), 1'b0, 1'b0};
        n++;
      end
    end
    // Flush the bottom row with nothing below it
    if (end_frame) begin
      for (int j = 0; j < cols; j++) begin
        batch[n] = '{rule_b3s23(line_mid, line_cur, '0, j, cols),
                     ROW_W'(r), COL_W'(j), 1'b0, (j == cols - 1)};
        n++;
      end
    end
    if (n > 0) batch[n - 1].last = 1'b1;
    if (record) begin
      for (int k = 0; k < n; k++) next_gen_q.push_back(batch[k]);
    end
    if (end_frame) begin
      wipe_lines();
    end else if (end_row) begin
      line_up  = line_mid;
      line_mid = line_cur;
      line_cur = '0;
      at_col   = 0;
      at_row   = r + 1;
    end else begin
      at_col = c + 1;
      at_row = r;
    end
  endtask

  // Offer one cell, with a random gap whenever a burst runs out
  task automatic push_cell(input logic alive, input bit record);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - 1){1'b0}}, alive};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    evolve_cell(alive, record);
  endtask

  // Stop offering and wait until every owed cell has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_COLS) grid_cols_q = data[CFG_COLS_W-1:0];
    else grid_rows_q = data[CFG_ROWS_W-1:0];
    wipe_lines();
    @(posedge clk);
  endtask

  // Reconfigure, then stream whole frames of random cells, some cut short
  task automatic random_phase(input logic [CFG_DATA_W-1:0] cols_val,
                              input logic [CFG_DATA_W-1:0] rows_val,
                              input bit set_cols, input bit set_rows,
                              input int frames, input bit allow_cut, input bit squeeze);
    int cells;
    int count;
    int density;
    bit cut;
    settle();
    if (set_cols) cfg_write(REG_GRID_COLS, cols_val);
    if (set_rows) cfg_write(REG_GRID_ROWS, rows_val);
    if (squeeze) hold_req = 1'b1;
    cells = live_cols() * live_rows();
    for (int f = 0; f < frames; f++) begin
      density = $urandom_range(10, 90);
      cut = allow_cut && ($urandom_range(0, 5) == 0);
      count = cut ? $urandom_range(1, cells) : cells;
      for (int i = 0; i < count; i++) begin
        push_cell($urandom_range(0, 99) < density, 1'b1);
        random_cells++;
      end
      if (cut) break;
    end
  endtask

  task automatic flag_fault(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  // Receiver: ready pattern in segments, plus a long hold on request
  initial begin : rx_pattern
    int seg;
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 120);
      for (int k = 0; k < seg; k++) begin
        @(posedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 3) != 0);
            2: out_tready <= ($urandom_range(0, 2) == 0);
            default: out_tready <= ~out_tready;
          endcase
        end
      end
    end
  end

  // Check each output transaction against the oldest owed cell
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tdata[0], out_tdata[10:1], out_tdata[15:11], out_tlast, out_tuser};
      if (next_gen_q.size() == 0) begin
        flag_fault($sformatf("unexpected result: alive %0b row %0d col %0d last %0b eog %0b",
                             seen.alive, seen.row, seen.col, seen.last, seen.eog));
      end else begin
        owed = next_gen_q.pop_front();
        if (seen.alive !== owed.alive || seen.row !== owed.row || seen.col !== owed.col ||
            seen.last !== owed.last || seen.eog !== owed.eog) begin
          flag_fault($sformatf({"result mismatch: want alive %0b row %0d col %0d last %0b ",
                                "eog %0b, got alive %0b row %0d col %0d last %0b eog %0b"},
                               owed.alive, owed.row, owed.col, owed.last, owed.eog,
                               seen.alive, seen.row, seen.col, seen.last, seen.eog));
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int                    pick;
    int                    cols_v;
    int                    rows_v;
    logic [1:0]            which;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed plan
    for (int i = 0; i < $size(PLAN); i++) begin
      case (PLAN[i].kind)
        STEP_CFG: begin
          settle();
          cfg_write(PLAN[i].idx, PLAN[i].data);
        end
        STEP_CELL: push_cell(PLAN[i].alive_in, 1'b1);
        default: begin
          push_cell(PLAN[i].alive_in, 1'b0);
          next_gen_q.push_back(PLAN[i].want);
        end
      endcase
    end

    // Extremes: widest grid under a long output hold, oversized columns, tallest grid
    random_phase(11'd32, 11'd3, 1'b1, 1'b1, 1, 1'b0, 1'b1);
    random_phase(11'd63, 11'd2, 1'b1, 1'b1, 1, 1'b0, 1'b0);
    // Stream only the top rows of the tallest grid; the next write restarts the frame
    random_phase(11'd0, 11'h7FF, 1'b1, 1'b1, 0, 1'b0, 1'b0);
    for (int i = 0; i < TALL_CELLS; i++) begin
      push_cell(1'($urandom_range(0, 1)), 1'b1);
    end

    // Random geometries, mostly small
    random_cells = 0;
    while (random_cells < RANDOM_ITEMS) begin
      pick   = $urandom_range(0, 11);
      cols_v = $urandom_range(1, 8);
      rows_v = $urandom_range(1, 6);
      case (pick)
        0: cols_v = 0;
        1: cols_v = $urandom_range(33, 63);
        2: rows_v = 0;
        3: cols_v = $urandom_range(9, 32);
        default: ;
      endcase
      which = 2'($urandom_range(1, 3));
      random_phase({5'($urandom), 6'(cols_v)}, 11'(rows_v), which[0], which[1],
                   $urandom_range(1, 3), 1'b1, (pick == 4) && !hold_req);
    end

    settle();
    if (mismatches == 0 && next_gen_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
